// ===== rtl/rmq_pkg.sv =====
// shared constants and types for the rotation matrix to quaternion block
`default_nettype none
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int FIELD_W = 18;
	// width of a sum or difference of two elements
	localparam int D_W = FIELD_W + 1;

	typedef enum logic [1:0] {
		PATH_X = 2'd0,
		PATH_Y = 2'd1,
		PATH_Z = 2'd2,
		PATH_W = 2'd3
	} path_t;

	// path, then the three off-diagonal combinations in component order
	localparam int SIDE_W = 2 + 3 * D_W;

endpackage
`default_nettype wire

// ===== rtl/rmq_front.sv =====
// front end: trace, path choice, radicand and off-diagonal combinations
`default_nettype none
module rmq_front import rmq_pkg::*; #(
	parameter int F = FRAC_BITS_DEF,
	localparam int RW = ((F + 1 > 20) ? F + 1 : 20) + 2,
	localparam int UW = RW - 1
) (
	input  wire logic signed [FIELD_W-1:0] r00,
	input  wire logic signed [FIELD_W-1:0] r01,
	input  wire logic signed [FIELD_W-1:0] r02,
	input  wire logic signed [FIELD_W-1:0] r10,
	input  wire logic signed [FIELD_W-1:0] r11,
	input  wire logic signed [FIELD_W-1:0] r12,
	input  wire logic signed [FIELD_W-1:0] r20,
	input  wire logic signed [FIELD_W-1:0] r21,
	input  wire logic signed [FIELD_W-1:0] r22,
	output logic [UW+SIDE_W-1:0] item
);

	localparam logic signed [RW-1:0] ONE_S = RW'(64'd1 << F);

	logic signed [RW-1:0] tr, rad;
	logic signed [D_W-1:0] d0, d1, d2;
	logic [UW-1:0] rad_u;
	path_t path;

	assign tr = RW'(r00) + RW'(r11) + RW'(r22);

	always_comb begin
		if (tr > 0) begin
			path = PATH_W;
			rad = ONE_S + tr;
			d0 = D_W'(r21) - D_W'(r12);
			d1 = D_W'(r02) - D_W'(r20);
			d2 = D_W'(r10) - D_W'(r01);
		end else if (r00 > r11 && r00 > r22) begin
			path = PATH_X;
			rad = ONE_S + RW'(r00) - RW'(r11) - RW'(r22);
			d0 = D_W'(r01) + D_W'(r10);
			d1 = D_W'(r20) + D_W'(r02);
			d2 = D_W'(r21) - D_W'(r12);
		end else if (r11 > r22) begin
			path = PATH_Y;
			rad = ONE_S + RW'(r11) - RW'(r00) - RW'(r22);
			d0 = D_W'(r01) + D_W'(r10);
			d1 = D_W'(r12) + D_W'(r21);
			d2 = D_W'(r02) - D_W'(r20);
		end else begin
			path = PATH_Z;
			rad = ONE_S + RW'(r22) - RW'(r00) - RW'(r11);
			d0 = D_W'(r02) + D_W'(r20);
			d1 = D_W'(r12) + D_W'(r21);
			d2 = D_W'(r10) - D_W'(r01);
		end
	end

	// radicand below one lsb is clamped to one lsb
	assign rad_u = (rad < 1) ? UW'(1) : rad[UW-1:0];
	assign item = {rad_u, path, d0, d1, d2};

endmodule
`default_nettype wire

// ===== rtl/rmq_queue.sv =====
// short queue between the front end and the arithmetic back end
`default_nettype none
module rmq_queue import rmq_pkg::*; #(
	parameter int W = 8,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic [W-1:0] wdata,
	input  wire logic pop,
	output logic [W-1:0] rdata,
	output logic full,
	output logic empty
);

	logic [W-1:0] mem [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0] count_q;

	assign full = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !empty) else $error("transfer into queue lost");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/rmq_back.sv =====
// back end: pipelined square root, reciprocal, scaling and saturation
`default_nettype none
module rmq_back import rmq_pkg::*; #(
	parameter int F = FRAC_BITS_DEF,
	localparam int RW = ((F + 1 > 20) ? F + 1 : 20) + 2,
	localparam int UW = RW - 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [UW+SIDE_W-1:0] head,
	input  wire logic head_valid,
	output logic head_pop,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [FIELD_W-1:0] qx,
	output logic signed [FIELD_W-1:0] qy,
	output logic signed [FIELD_W-1:0] qz,
	output logic signed [FIELD_W-1:0] qw
);

	localparam int VW = UW + F;
	localparam int NS = (VW + 1) / 2;
	localparam int RMW = NS + 2;
	localparam int QW = 2 * F;
	localparam int SW = F + 2;
	localparam int PW = D_W + SW;
	localparam longint ONE_L = longint'(1) << F;
	localparam longint HI = (ONE_L < 131071) ? ONE_L : 131071;
	localparam longint LOM = (ONE_L < 131072) ? ONE_L : 131072;
	localparam logic [PW:0] HALF = (PW+1)'(64'd1 << (F - 1));

	logic en;
	assign en = !out_valid || !out_stall;
	assign head_pop = en && head_valid;

	// square root, two radicand bits a stage
	logic [NS-1:0] sq_root [NS];
	logic [RMW-1:0] sq_rem [NS];
	logic [2*NS-1:0] sq_rad [NS];
	logic [SIDE_W-1:0] sq_side [NS];
	logic sq_v [NS];

	for (genvar k = 0; k < NS; k++) begin : g_sq
		logic [NS-1:0] root_i;
		logic [RMW-1:0] rem_i, r2, trial;
		logic [2*NS-1:0] rad_i;
		logic [SIDE_W-1:0] side_i;
		logic v_i, ge;
		if (k == 0) begin : g_first
			assign root_i = '0;
			assign rem_i = '0;
			assign rad_i = (2*NS)'(head[UW+SIDE_W-1:SIDE_W]) << F;
			assign side_i = head[SIDE_W-1:0];
			assign v_i = head_valid;
		end else begin : g_next
			assign root_i = sq_root[k-1];
			assign rem_i = sq_rem[k-1];
			assign rad_i = sq_rad[k-1];
			assign side_i = sq_side[k-1];
			assign v_i = sq_v[k-1];
		end
		assign r2 = {rem_i[RMW-3:0], rad_i[2*NS-1 -: 2]};
		assign trial = {root_i, 2'b01};
		assign ge = (r2 >= trial);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k] <= 1'b0;
			end else if (en) begin
				sq_v[k] <= v_i;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_root[k] <= {root_i[NS-2:0], ge};
				sq_rem[k] <= ge ? r2 - trial : r2;
				sq_rad[k] <= rad_i << 2;
				sq_side[k] <= side_i;
			end
		end
	end

	// s = 2^(2F-1) / root, restoring division one quotient bit a stage
	logic [NS-1:0] dv_root [QW];
	logic [NS-1:0] dv_rem [QW];
	logic [QW-1:0] dv_q [QW];
	logic [SIDE_W-1:0] dv_side [QW];
	logic dv_v [QW];

	for (genvar j = 0; j < QW; j++) begin : g_dv
		logic [NS-1:0] root_i, rem_i;
		logic [QW-1:0] q_i;
		logic [SIDE_W-1:0] side_i;
		logic v_i, ge;
		logic [NS:0] r2, diff;
		if (j == 0) begin : g_first
			assign root_i = sq_root[NS-1];
			assign rem_i = '0;
			assign q_i = '0;
			assign side_i = sq_side[NS-1];
			assign v_i = sq_v[NS-1];
			assign r2 = {rem_i, 1'b1};
		end else begin : g_next
			assign root_i = dv_root[j-1];
			assign rem_i = dv_rem[j-1];
			assign q_i = dv_q[j-1];
			assign side_i = dv_side[j-1];
			assign v_i = dv_v[j-1];
			assign r2 = {rem_i, 1'b0};
		end
		assign ge = (r2 >= {1'b0, root_i});
		assign diff = r2 - {1'b0, root_i};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j] <= 1'b0;
			end else if (en) begin
				dv_v[j] <= v_i;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_root[j] <= root_i;
				dv_rem[j] <= ge ? diff[NS-1:0] : r2[NS-1:0];
				dv_q[j] <= {q_i[QW-2:0], ge};
				dv_side[j] <= side_i;
			end
		end
	end

	// multiply stage; any s above 2^(F+1) is clamped to 2^(F+1)
	logic [SW-1:0] s_c;
	logic [SIDE_W-1:0] side_m;
	logic signed [D_W-1:0] dm [3];
	logic [D_W-1:0] mag [3];
	logic [PW-1:0] prod_s1 [3];
	logic neg_s1 [3];
	logic [NS-1:0] root_s1;
	path_t path_s1;
	logic v_s1;

	assign side_m = dv_side[QW-1];
	assign dm[0] = side_m[3*D_W-1 -: D_W];
	assign dm[1] = side_m[2*D_W-1 -: D_W];
	assign dm[2] = side_m[D_W-1:0];
	assign s_c = (|dv_q[QW-1][QW-1:F+1]) ? SW'(64'd1 << (F + 1)) : dv_q[QW-1][F+1:0];

	for (genvar c = 0; c < 3; c++) begin : g_mul
		assign mag[c] = dm[c][D_W-1] ? D_W'(0) - dm[c] : dm[c];
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[c] <= PW'(mag[c]) * PW'(s_c);
				neg_s1[c] <= dm[c][D_W-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= dv_v[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_s1 <= dv_root[QW-1];
			path_s1 <= path_t'(side_m[SIDE_W-1 -: 2]);
		end
	end

	// round half away from zero, then clamp
	function automatic logic [FIELD_W-1:0] scale_sat(input logic [PW-1:0] p, input logic neg);
		logic [PW:0] r;
		r = ({1'b0, p} + HALF) >> F;
		if (neg) begin
			if (64'(r) > 64'(LOM)) begin
				return FIELD_W'(-LOM);
			end
			return FIELD_W'(0) - r[FIELD_W-1:0];
		end
		if (64'(r) > 64'(HI)) begin
			return FIELD_W'(HI);
		end
		return r[FIELD_W-1:0];
	endfunction

	logic [NS:0] rootp1;
	logic [FIELD_W-1:0] big, c0, c1, c2;
	path_t path_q;

	assign rootp1 = {1'b0, root_s1} + 1'b1;
	assign big = (64'(rootp1[NS:1]) > 64'(HI)) ? FIELD_W'(HI) : FIELD_W'(rootp1[NS:1]);
	assign c0 = scale_sat(prod_s1[0], neg_s1[0]);
	assign c1 = scale_sat(prod_s1[1], neg_s1[1]);
	assign c2 = scale_sat(prod_s1[2], neg_s1[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			path_q <= path_s1;
			unique case (path_s1)
				PATH_X: begin
					qx <= big; qy <= c0; qz <= c1; qw <= c2;
				end
				PATH_Y: begin
					qx <= c0; qy <= big; qz <= c1; qw <= c2;
				end
				PATH_Z: begin
					qx <= c0; qy <= c1; qz <= big; qw <= c2;
				end
				PATH_W: begin
					qx <= c0; qy <= c1; qz <= c2; qw <= big;
				end
				default: begin
					qx <= c0; qy <= c1; qz <= c2; qw <= big;
				end
			endcase
		end
	end

	// the component taken from the root is never negative
	a_own_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((path_q == PATH_X) ? !qx[FIELD_W-1] :
			(path_q == PATH_Y) ? !qy[FIELD_W-1] :
			(path_q == PATH_Z) ? !qz[FIELD_W-1] : !qw[FIELD_W-1]))
		else $error("own component negative");

endmodule
`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion (Shepperd's method) in signed Q(FRAC_BITS) fixed
// point. One matrix is taken per cycle and one quaternion leaves per cycle while
// neither side is stalled. Each matrix passes through the queue, the square root
// pipeline of depth NS = ceil((FRAC_BITS + max(FRAC_BITS+1, 20) + 1) / 2), the
// reciprocal divider of depth 2*FRAC_BITS, the multiply register and the output
// register. The front end classifies each matrix into a small queue, so input
// transfers continue while the output is stalled until the queue fills.
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [FIELD_W-1:0] r00,
	input  wire logic signed [FIELD_W-1:0] r01,
	input  wire logic signed [FIELD_W-1:0] r02,
	input  wire logic signed [FIELD_W-1:0] r10,
	input  wire logic signed [FIELD_W-1:0] r11,
	input  wire logic signed [FIELD_W-1:0] r12,
	input  wire logic signed [FIELD_W-1:0] r20,
	input  wire logic signed [FIELD_W-1:0] r21,
	input  wire logic signed [FIELD_W-1:0] r22,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [FIELD_W-1:0] qx,
	output logic signed [FIELD_W-1:0] qy,
	output logic signed [FIELD_W-1:0] qz,
	output logic signed [FIELD_W-1:0] qw
);

	localparam int RW = ((FRAC_BITS + 1 > 20) ? FRAC_BITS + 1 : 20) + 2;
	localparam int IW = RW - 1 + SIDE_W;

	logic [IW-1:0] item, head;
	logic full, empty, pop, push;

	assign in_stall = full;
	assign push = in_valid && !full;

	rmq_front #(.F(FRAC_BITS)) u_front (
		.r00(r00), .r01(r01), .r02(r02),
		.r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22),
		.item(item)
	);

	rmq_queue #(.W(IW), .DEPTH(DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(item),
		.pop(pop), .rdata(head),
		.full(full), .empty(empty)
	);

	rmq_back #(.F(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .head_valid(!empty), .head_pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.qx(qx), .qy(qy), .qz(qz), .qw(qw)
	);

endmodule
`default_nettype wire

// ===== dv/rotation_matrix_to_quaternion_checker.sv =====
// checker: watches both channels, predicts each quaternion and compares it
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_checker import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic signed [FIELD_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic signed [FIELD_W-1:0] qx, qy, qz, qw,
	output int errors,
	output int pending
);

	typedef struct packed {
		logic signed [FIELD_W-1:0] x, y, z, w;
	} quat_t;

	quat_t quat_q[$];

	function automatic longint clamp_unit(longint v);
		longint one, hi, lo;
		one = longint'(1) << FRAC_BITS;
		hi = (longint'(1) << (FIELD_W - 1)) - 1;
		lo = -(longint'(1) << (FIELD_W - 1));
		if (hi > one) hi = one;
		if (lo < -one) lo = -one;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic longint scaled(longint d, longint unsigned s);
		longint unsigned mag, p;
		mag = (d < 0) ? longint'(-d) : longint'(d);
		p = (mag * s + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return clamp_unit(d < 0 ? -longint'(p) : longint'(p));
	endfunction

	function automatic quat_t shepperd(longint m00, m01, m02, m10, m11, m12, m20, m21, m22);
		longint one, tr, rad;
		longint unsigned v, res, b, root, s;
		path_t path;
		quat_t q;
		longint big;
		one = longint'(1) << FRAC_BITS;
		tr = m00 + m11 + m22;
		if (tr > 0) begin
			path = PATH_W;
			rad = one + tr;
		end else if (m00 > m11 && m00 > m22) begin
			path = PATH_X;
			rad = one + m00 - m11 - m22;
		end else if (m11 > m22) begin
			path = PATH_Y;
			rad = one + m11 - m00 - m22;
		end else begin
			path = PATH_Z;
			rad = one + m22 - m00 - m11;
		end
		if (rad < 1) rad = 1;
		v = longint'(rad) << FRAC_BITS;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		root = res;
		s = (64'd1 << (2 * FRAC_BITS - 1)) / root;
		big = clamp_unit(longint'((root + 1) >> 1));
		case (path)
			PATH_W: begin
				q.x = FIELD_W'(scaled(m21 - m12, s)); q.y = FIELD_W'(scaled(m02 - m20, s));
				q.z = FIELD_W'(scaled(m10 - m01, s)); q.w = FIELD_W'(big);
			end
			PATH_X: begin
				q.x = FIELD_W'(big); q.y = FIELD_W'(scaled(m01 + m10, s));
				q.z = FIELD_W'(scaled(m20 + m02, s)); q.w = FIELD_W'(scaled(m21 - m12, s));
			end
			PATH_Y: begin
				q.x = FIELD_W'(scaled(m01 + m10, s)); q.y = FIELD_W'(big);
				q.z = FIELD_W'(scaled(m12 + m21, s)); q.w = FIELD_W'(scaled(m02 - m20, s));
			end
			default: begin
				q.x = FIELD_W'(scaled(m02 + m20, s)); q.y = FIELD_W'(scaled(m12 + m21, s));
				q.z = FIELD_W'(big); q.w = FIELD_W'(scaled(m10 - m01, s));
			end
		endcase
		return q;
	endfunction

	assign pending = quat_q.size();

	always @(posedge clk) begin
		quat_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				quat_q.push_back(shepperd(r00, r01, r02, r10, r11, r12, r20, r21, r22));
			if (out_valid && !out_stall) begin
				if (quat_q.size() == 0) begin
					$error("quaternion transfer with nothing expected");
					errors++;
				end else begin
					e = quat_q.pop_front();
					if (qx !== e.x) begin $error("qx expected %0d got %0d", e.x, qx); errors++; end
					if (qy !== e.y) begin $error("qy expected %0d got %0d", e.y, qy); errors++; end
					if (qz !== e.z) begin $error("qz expected %0d got %0d", e.z, qz); errors++; end
					if (qw !== e.w) begin $error("qw expected %0d got %0d", e.w, qw); errors++; end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== dv/rotation_matrix_to_quaternion_test.sv =====
// testbench top: drives matrices, stalls the output and gives the verdict
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_test;
	import rmq_pkg::*;

	localparam int ONE = 1 << FRAC_BITS_DEF;
	localparam int LATENCY = 9 + 17 + 32 + 2 + 8;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_stall = 0;
	logic signed [FIELD_W-1:0] m [9] = '{default: '0};
	logic in_stall, out_valid;
	logic signed [FIELD_W-1:0] qx, qy, qz, qw;
	int errors, pending, idle_cycles;
	bit calm;

	always #2 clk = ~clk;

	rotation_matrix_to_quaternion DUT (
		.clk, .arst_n, .in_valid, .in_stall,
		.r00(m[0]), .r01(m[1]), .r02(m[2]), .r10(m[3]), .r11(m[4]), .r12(m[5]),
		.r20(m[6]), .r21(m[7]), .r22(m[8]),
		.out_valid, .out_stall, .qx, .qy, .qz, .qw
	);

	rotation_matrix_to_quaternion_checker checker_i (
		.clk, .arst_n, .in_valid, .in_stall,
		.r00(m[0]), .r01(m[1]), .r02(m[2]), .r10(m[3]), .r11(m[4]), .r12(m[5]),
		.r20(m[6]), .r21(m[7]), .r22(m[8]),
		.out_valid, .out_stall, .qx, .qy, .qz, .qw, .errors, .pending
	);

	// output stall, with a quiet stretch in the middle of the run
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 7);

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("rotation_matrix_to_quaternion_test: errors");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	function automatic logic signed [FIELD_W-1:0] near_unit();
		case ($urandom_range(5))
			0: return FIELD_W'($urandom);
			1: return FIELD_W'(int'($urandom_range(2 * ONE)) - ONE);
			2: return FIELD_W'(ONE);
			3: return FIELD_W'(-ONE);
			default: return FIELD_W'(int'($urandom_range(2 * ONE)) - ONE);
		endcase
	endfunction

	// one matrix transfer; valid stays high across back-to-back transfers
	task automatic send_matrix(input logic signed [FIELD_W-1:0] e [9]);
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		foreach (m[i]) m[i] <= e[i];
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_diag(input int d0, d1, d2, input int off);
		logic signed [FIELD_W-1:0] e [9];
		foreach (e[i]) e[i] = FIELD_W'(off + i);
		e[0] = FIELD_W'(d0); e[4] = FIELD_W'(d1); e[8] = FIELD_W'(d2);
		send_matrix(e);
	endtask

	initial begin
		logic signed [FIELD_W-1:0] e [9];
		calm = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// identity, each trace-negative path and ties
		send_diag(ONE, ONE, ONE, 0);
		send_diag(ONE, -ONE, -ONE, 100);
		send_diag(-ONE, ONE, -ONE, -100);
		send_diag(-ONE, -ONE, ONE, 300);
		send_diag(-ONE, -ONE, -ONE, 0);
		send_diag(0, 0, 0, 5);
		send_diag(-5, -5, 10, 7);
		send_diag(0, 0, -1, 1);
		send_diag(-ONE / 2, -ONE / 2, -ONE / 2, 0);
		send_diag(-131072, -131072, -131072, 0);
		send_diag(131071, 131071, 131071, 0);
		send_diag(-131072, 131071, -131072, 0);
		send_diag(-10, -20, -20, 0);
		foreach (e[i]) e[i] = FIELD_W'(-131072);
		send_matrix(e);
		foreach (e[i]) e[i] = FIELD_W'(131071);
		send_matrix(e);
		foreach (e[i]) e[i] = FIELD_W'((i % 2) ? -131072 : 131071);
		send_matrix(e);
		foreach (e[i]) e[i] = FIELD_W'((i % 2) ? ONE : -ONE);
		send_matrix(e);
		for (int n = 0; n < 1950; n++) begin
			calm = (n >= 800 && n < 1100);
			if ($urandom_range(9) == 0) begin
				foreach (e[i]) e[i] = FIELD_W'($urandom);
				send_matrix(e);
			end else if ($urandom_range(3) == 0)
				send_diag(-ONE + int'($urandom_range(40)), -ONE + int'($urandom_range(40)),
					-ONE + int'($urandom_range(40)), int'($urandom_range(2000)) - 1000);
			else begin
				foreach (e[i]) e[i] = near_unit();
				send_matrix(e);
			end
		end
		calm = 0;
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (errors == 0)
			$display("rotation_matrix_to_quaternion_test: clean");
		else
			$display("rotation_matrix_to_quaternion_test: errors");
		$finish;
	end

endmodule
`default_nettype wire

// ===== rotation_matrix_to_quaternion.f =====
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_queue.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion.sv
dv/rotation_matrix_to_quaternion_checker.sv
dv/rotation_matrix_to_quaternion_test.sv
